[hdl/xbs_pkg.sv]
// Package for the XMODEM block sender: codes, phase type, result record
// and the CRC-16 byte update. No dependencies.
package xbs_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int ADDR_W      = $clog2(BLOCK_BYTES);
    localparam int CFG_ADDR_W  = 2;

    // frame layout: SOH, number, complement, data, trailer
    localparam logic [7:0] DATA_START  = 8'd3;
    localparam logic [7:0] TRAILER_POS = 8'(BLOCK_BYTES + 3);
    localparam logic [7:0] LAST_SUM    = 8'(BLOCK_BYTES + 3);
    localparam logic [7:0] LAST_CRC    = 8'(BLOCK_BYTES + 4);

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] RST_TRIES  = 8'd6;
    localparam logic [7:0] RST_MARKER = 8'd26;
    localparam logic [7:0] RST_PAD    = 8'd32;

    localparam logic [CFG_ADDR_W-1:0] REG_TRIES  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MARKER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAD    = 2'd2;

    typedef enum logic [1:0] {
        MODE_FILE = 2'd0,
        MODE_EOF  = 2'd1,
        MODE_RX   = 2'd2,
        MODE_SLOT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_HANDSHAKE = 3'd0,
        PH_FILLING   = 3'd1,
        PH_SENDING   = 3'd2,
        PH_AWAIT     = 3'd3,
        PH_ENDING    = 3'd4,
        PH_DONE      = 3'd5,
        PH_ABORTED   = 3'd6
    } phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_taken;
        phase_t     phase;
        logic       crc_mode;
    } result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hdl/xbs_block_buf.sv]
// Block buffer: one write port, one read port, registered read data.
// Depends on xbs_pkg.
module xbs_block_buf (
    input  logic                       clk,
    input  logic                       we,
    input  logic [xbs_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic                       re,
    input  logic [xbs_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [xbs_pkg::BLOCK_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read, so a stalled result keeps it
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/xmodem_block_sender.sv]
// XMODEM block sender top level: sequencer, check accumulation and the
// two-stage result path. Depends on xbs_pkg and xbs_block_buf.
//
// Usage: each request on the s_ side carries a kind in s_tuser (file byte,
// end of file, receiver byte, transmit slot) and a byte in s_tdata. Every
// request gives exactly one result on the m_ side: a line byte when
// m_tuser is high, plus the data-taken flag, the phase and the check mode.
// A result passes the two registered result stages before it shows on m_;
// one request is taken per cycle while s_tready is high. The frame
// bytes of the data part come from the block buffer, whose registered read
// data feeds the second stage.
// End of file writes the marker and then sweeps pad bytes into the buffer,
// one byte a cycle; s_tready stays low until the sweep has filled the block
// after such a request. The result of that request leaves at once.
// A stall on m_tready fills the two result stages and then drops s_tready.
// Reset (rst_n low) returns to the handshake phase with block number 1,
// checksum mode, registers at 6 / 26 / 32, and empties the result path.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once
// and belong to idle periods only.
module xmodem_block_sender (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [xbs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte[7:0]
    input  logic [1:0]                     s_tuser,   // mode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tx_byte[7:0], data_taken[8], phase[11:9], crc_mode[12], zero[15:13]
    output logic [15:0]                    m_tdata,
    output logic                           m_tuser    // tx_valid
);

    localparam int AW = xbs_pkg::ADDR_W;

    // configuration
    logic [7:0] tries_cfg_reg, marker_cfg_reg, pad_cfg_reg;

    // sequencer state
    xbs_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  fill_reg, fill_next;
    logic [7:0]  send_reg, send_next;
    logic [7:0]  blk_reg, blk_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next;
    logic        crc_sel_reg, crc_sel_next;
    logic [7:0]  tries_reg, tries_next;
    logic        eof_reg, eof_next;
    logic        pad_busy_reg, pad_busy_next;

    // result stages
    logic             p_valid_reg, o_valid_reg;
    xbs_pkg::result_t p_res_reg, o_res_reg;
    logic             p_mem_reg;
    xbs_pkg::result_t res_now;
    logic             res_mem;

    // buffer ports
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    logic          accept, p_adv;
    xbs_pkg::mode_t mode_in;
    logic [7:0]    tries_inc;
    logic [7:0]    store_byte;
    logic          store_en;

    assign mode_in = xbs_pkg::mode_t'(s_tuser);
    assign p_adv   = p_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !pad_busy_reg && (!p_valid_reg || !o_valid_reg || m_tready);
    assign accept  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tries_cfg_reg  <= xbs_pkg::RST_TRIES;
            marker_cfg_reg <= xbs_pkg::RST_MARKER;
            pad_cfg_reg    <= xbs_pkg::RST_PAD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                xbs_pkg::REG_TRIES:  tries_cfg_reg  <= cfg_wdata;
                xbs_pkg::REG_MARKER: marker_cfg_reg <= cfg_wdata;
                xbs_pkg::REG_PAD:    pad_cfg_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= xbs_pkg::PH_HANDSHAKE;
            fill_reg     <= 8'd0;
            send_reg     <= 8'd0;
            blk_reg      <= 8'd1;
            crc_reg      <= 16'd0;
            sum_reg      <= 8'd0;
            crc_sel_reg  <= 1'b0;
            tries_reg    <= 8'd0;
            eof_reg      <= 1'b0;
            pad_busy_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            send_reg     <= send_next;
            blk_reg      <= blk_next;
            crc_reg      <= crc_next;
            sum_reg      <= sum_next;
            crc_sel_reg  <= crc_sel_next;
            tries_reg    <= tries_next;
            eof_reg      <= eof_next;
            pad_busy_reg <= pad_busy_next;
        end
    end

    assign tries_inc = (tries_reg == 8'hFF) ? tries_reg : tries_reg + 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        send_next     = send_reg;
        blk_next      = blk_reg;
        crc_next      = crc_reg;
        sum_next      = sum_reg;
        crc_sel_next  = crc_sel_reg;
        tries_next    = tries_reg;
        eof_next      = eof_reg;
        pad_busy_next = pad_busy_reg;
        store_en      = 1'b0;
        store_byte    = s_tdata;
        mem_re        = 1'b0;
        mem_raddr     = AW'(send_reg - xbs_pkg::DATA_START);
        res_now.tx_valid   = 1'b0;
        res_now.tx_byte    = 8'd0;
        res_now.data_taken = 1'b0;
        res_mem            = 1'b0;

        if (pad_busy_reg)
        begin
            store_en   = 1'b1;
            store_byte = pad_cfg_reg;
            if (fill_reg == 8'(xbs_pkg::BLOCK_BYTES - 1))
                pad_busy_next = 1'b0;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                xbs_pkg::PH_HANDSHAKE:
                begin
                    if (mode_in == xbs_pkg::MODE_RX)
                    begin
                        if (s_tdata == xbs_pkg::CH_C)
                        begin
                            crc_sel_next = 1'b1;
                            phase_next   = xbs_pkg::PH_FILLING;
                        end
                        else if (s_tdata == xbs_pkg::CH_NAK)
                        begin
                            crc_sel_next = 1'b0;
                            phase_next   = xbs_pkg::PH_FILLING;
                        end
                        else
                        begin
                            tries_next = tries_inc;
                            if (tries_inc >= tries_cfg_reg)
                            begin
                                crc_sel_next = 1'b0;
                                phase_next   = xbs_pkg::PH_FILLING;
                            end
                        end
                    end
                end
                xbs_pkg::PH_FILLING:
                begin
                    if (mode_in == xbs_pkg::MODE_FILE)
                    begin
                        res_now.data_taken = 1'b1;
                        store_en           = 1'b1;
                        if (fill_reg == 8'(xbs_pkg::BLOCK_BYTES - 1))
                        begin
                            send_next  = 8'd0;
                            phase_next = xbs_pkg::PH_SENDING;
                        end
                    end
                    else if (mode_in == xbs_pkg::MODE_EOF)
                    begin
                        // marker now, pad bytes swept in on the following cycles
                        res_now.data_taken = 1'b1;
                        store_en           = 1'b1;
                        store_byte         = marker_cfg_reg;
                        eof_next           = 1'b1;
                        send_next          = 8'd0;
                        phase_next         = xbs_pkg::PH_SENDING;
                        if (fill_reg != 8'(xbs_pkg::BLOCK_BYTES - 1))
                            pad_busy_next = 1'b1;
                    end
                end
                xbs_pkg::PH_SENDING:
                begin
                    if (mode_in == xbs_pkg::MODE_SLOT)
                    begin
                        res_now.tx_valid = 1'b1;
                        if (send_reg == 8'd0)
                            res_now.tx_byte = xbs_pkg::CH_SOH;
                        else if (send_reg == 8'd1)
                            res_now.tx_byte = blk_reg;
                        else if (send_reg == 8'd2)
                            res_now.tx_byte = ~blk_reg;
                        else if (send_reg < xbs_pkg::TRAILER_POS)
                        begin
                            mem_re  = 1'b1;
                            res_mem = 1'b1;
                        end
                        else if (crc_sel_reg && send_reg == xbs_pkg::TRAILER_POS)
                            res_now.tx_byte = crc_reg[15:8];
                        else if (crc_sel_reg)
                            res_now.tx_byte = crc_reg[7:0];
                        else
                            res_now.tx_byte = sum_reg;
                        send_next = send_reg + 8'd1;
                        if ((send_reg + 8'd1) >= (crc_sel_reg ? xbs_pkg::LAST_CRC
                                                              : xbs_pkg::LAST_SUM))
                            phase_next = xbs_pkg::PH_AWAIT;
                    end
                end
                xbs_pkg::PH_AWAIT:
                begin
                    if (mode_in == xbs_pkg::MODE_RX)
                    begin
                        if (s_tdata == xbs_pkg::CH_ACK)
                        begin
                            blk_next   = (blk_reg == 8'hFF) ? 8'd1 : blk_reg + 8'd1;
                            fill_next  = 8'd0;
                            send_next  = 8'd0;
                            crc_next   = 16'd0;
                            sum_next   = 8'd0;
                            phase_next = eof_reg ? xbs_pkg::PH_ENDING : xbs_pkg::PH_FILLING;
                        end
                        else if (s_tdata == xbs_pkg::CH_CAN)
                            phase_next = xbs_pkg::PH_ABORTED;
                        else
                        begin
                            send_next  = 8'd0;
                            phase_next = xbs_pkg::PH_SENDING;
                        end
                    end
                end
                xbs_pkg::PH_ENDING:
                begin
                    if (mode_in == xbs_pkg::MODE_SLOT)
                    begin
                        res_now.tx_valid = 1'b1;
                        res_now.tx_byte  = xbs_pkg::CH_EOT;
                    end
                    else if (mode_in == xbs_pkg::MODE_RX && s_tdata == xbs_pkg::CH_ACK)
                        phase_next = xbs_pkg::PH_DONE;
                end
                default: ;
            endcase
        end

        // every buffer write also feeds the running checks
        if (store_en)
        begin
            fill_next = fill_reg + 8'd1;
            crc_next  = xbs_pkg::crc16_update(crc_reg, store_byte);
            sum_next  = sum_reg + store_byte;
        end

        res_now.phase    = phase_next;
        res_now.crc_mode = crc_sel_next;
    end

    assign mem_we    = store_en;
    assign mem_waddr = fill_reg[AW-1:0];
    assign mem_wdata = store_byte;

    xbs_block_buf u_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                p_valid_reg <= 1'b1;
            else if (p_adv)
                p_valid_reg <= 1'b0;
            if (p_adv)
                o_valid_reg <= 1'b1;
            else if (m_tready)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_res_reg <= res_now;
            p_mem_reg <= res_mem;
        end
        if (p_adv)
        begin
            o_res_reg.tx_valid   <= p_res_reg.tx_valid;
            o_res_reg.tx_byte    <= p_mem_reg ? mem_rdata : p_res_reg.tx_byte;
            o_res_reg.data_taken <= p_res_reg.data_taken;
            o_res_reg.phase      <= p_res_reg.phase;
            o_res_reg.crc_mode   <= p_res_reg.crc_mode;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_res_reg.tx_valid;
    assign m_tdata  = {3'b000, o_res_reg.crc_mode, o_res_reg.phase,
                       o_res_reg.data_taken, o_res_reg.tx_byte};

endmodule
